// ===== design/gdu_pkg.sv =====
// Shared types and constants for the gradient-gated depth unprojection block.
// No dependencies.
package gdu_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int FIFO_DEPTH_DEF = 4;
  localparam int RECIP_STAGES = 33;

  localparam logic [2:0] REG_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_PRINCIPAL = 3'd1;
  localparam logic [2:0] REG_INV_FOCAL = 3'd2;
  localparam logic [2:0] REG_POSE_0 = 3'd3;
  localparam logic [2:0] REG_POSE_1 = 3'd4;
  localparam logic [2:0] REG_POSE_2 = 3'd5;

  typedef struct packed {
    logic [15:0] depth;
    logic [11:0] row;
    logic [11:0] col;
  } pixel_t;

  typedef struct packed {
    logic [2:0][63:0] pose;
    logic [63:0] inv_focal;
    logic [31:0] principal;
  } cam_cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

// ===== design/gdu_front.sv =====
// Front end: squared gradient magnitude gate in front of the point queue.
// Depends on gdu_pkg.
module gdu_front
  import gdu_pkg::*;
(
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [71:0]  s_tdata,
  input  logic [31:0]  threshold_sq,
  input  fifo_status_t status,
  output logic         push,
  output pixel_t       item
);

  logic signed [15:0] gx;
  logic signed [15:0] gy;
  logic signed [31:0] gx_w;
  logic signed [31:0] gy_w;
  logic [31:0] gx_sq;
  logic [31:0] gy_sq;
  logic [32:0] mag;

  assign gx = s_tdata[39:24];
  assign gy = s_tdata[55:40];
  assign gx_w = 32'(gx);
  assign gy_w = 32'(gy);
  assign gx_sq = gx_w * gx_w;
  assign gy_sq = gy_w * gy_w;
  assign mag = {1'b0, gx_sq} + {1'b0, gy_sq};

  assign s_tready = !status.full;
  assign push = s_tvalid && s_tready && (mag >= {1'b0, threshold_sq});
  assign item.col = s_tdata[11:0];
  assign item.row = s_tdata[23:12];
  assign item.depth = s_tdata[71:56];

endmodule

// ===== design/gdu_fifo.sv =====
// Short queue of kept pixels between front and back end.
// Depends on gdu_pkg.
module gdu_fifo
  import gdu_pkg::*;
#(
  parameter int DEPTH = FIFO_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  pixel_t       wr_item,
  input  logic         pop,
  output pixel_t       rd_item,
  output fifo_status_t status
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  pixel_t mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic do_push;
  logic do_pop;

  assign status.full = (count == CW'(DEPTH));
  assign status.empty = (count == '0);
  assign do_push = push && !status.full;
  assign do_pop = pop && !status.empty;
  assign rd_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    status.full && !do_pop |=> status.full)
    else $error("queue lost its fill");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count beyond depth");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    do_push && !do_pop |=> count == $past(count) + 1'b1)
    else $error("queue count did not advance");
`endif

endmodule

// ===== design/gdu_recip.sv =====
// Pipelined restoring divider giving 2^32 / z, one quotient bit per stage.
// Depends on gdu_pkg.
module gdu_recip
  import gdu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  logic        in_valid,
  input  logic [31:0] in_x,
  input  logic [31:0] in_y,
  input  logic [31:0] in_z,
  output logic        out_valid,
  output logic [31:0] out_x,
  output logic [31:0] out_y,
  output logic [31:0] out_z,
  output logic [31:0] out_inten,
  output logic        out_bad
);

  localparam int N = RECIP_STAGES;

  logic        v   [N+1];
  logic [31:0] x   [N+1];
  logic [31:0] y   [N+1];
  logic [31:0] z   [N+1];
  logic [31:0] dv  [N+1];
  logic        bad [N+1];
  logic [32:0] rem [N+1];
  logic [N-1:0] q  [N+1];

  logic in_bad;
  assign in_bad = in_z[31] || (in_z == '0);

  assign v[0] = in_valid;
  assign x[0] = in_x;
  assign y[0] = in_y;
  assign z[0] = in_z;
  assign bad[0] = in_bad;
  assign dv[0] = in_bad ? 32'd1 : in_z;
  assign rem[0] = '0;
  assign q[0] = '0;

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [33:0] trial;
    logic ge;
    assign trial = {rem[i], (i == 0) ? 1'b1 : 1'b0};
    assign ge = trial >= {2'b0, dv[i]};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (advance) begin
        v[i+1] <= v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        x[i+1] <= x[i];
        y[i+1] <= y[i];
        z[i+1] <= z[i];
        dv[i+1] <= dv[i];
        bad[i+1] <= bad[i];
        rem[i+1] <= ge ? 33'(trial - {2'b0, dv[i]}) : trial[32:0];
        q[i+1] <= {q[i][N-2:0], ge};
      end
    end
  end

  assign out_valid = v[N];
  assign out_x = x[N];
  assign out_y = y[N];
  assign out_z = z[N];
  assign out_bad = bad[N];
  assign out_inten = (bad[N] || q[N][N-1]) ? '1 : q[N][31:0];

endmodule

// ===== design/gdu_back.sv =====
// Back end: pinhole unprojection, pose transform, saturation, reciprocal.
// Depends on gdu_pkg and gdu_recip.
module gdu_back
  import gdu_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  cam_cfg_t     cfg,
  input  fifo_status_t status,
  input  pixel_t       rd_item,
  output logic         pop,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,
  output logic         m_tuser
);

  logic advance;
  assign advance = !m_tvalid || m_tready;
  assign pop = advance && !status.empty;

  logic [15:0] colm;
  logic [15:0] rowm;
  logic signed [20:0] dx;
  logic signed [20:0] dy;
  assign colm = 16'(rd_item.col) & 16'((1 << COORD_BITS) - 1);
  assign rowm = 16'(rd_item.row) & 16'((1 << COORD_BITS) - 1);
  assign dx = $signed({1'b0, colm, 4'b0}) - $signed({5'b0, cfg.principal[15:0]});
  assign dy = $signed({1'b0, rowm, 4'b0}) - $signed({5'b0, cfg.principal[31:16]});

  // stage 1: offset times reciprocal focal length
  logic v1;
  logic signed [53:0] p1x;
  logic signed [53:0] p1y;
  logic [15:0] dep1;
  // stage 2: times depth
  logic v2;
  logic signed [50:0] p2x;
  logic signed [50:0] p2y;
  logic [15:0] dep2;
  // stage 3: rotation products
  logic v3;
  logic signed [58:0] rp [3][3];
  logic signed [15:0] tr3 [3];
  // stage 4: saturated world point
  logic v4;
  logic [31:0] w4 [3];

  logic signed [42:0] cam [3];
  assign cam[0] = p2x[50:8];
  assign cam[1] = p2y[50:8];
  assign cam[2] = $signed({19'b0, dep2, 8'b0});

  logic signed [47:0] wsum [3];
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic signed [60:0] acc;
      acc = 61'(rp[a][0]) + 61'(rp[a][1]) + 61'(rp[a][2]);
      wsum[a] = 48'($signed(acc[60:14])) + 48'($signed({tr3[a], 8'b0}));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (advance) begin
      v1 <= !status.empty;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p1x <= dx * $signed({1'b0, cfg.inv_focal[31:0]});
      p1y <= dy * $signed({1'b0, cfg.inv_focal[63:32]});
      dep1 <= rd_item.depth;
      p2x <= $signed(p1x[53:20]) * $signed({1'b0, dep1});
      p2y <= $signed(p1y[53:20]) * $signed({1'b0, dep1});
      dep2 <= dep1;
      for (int a = 0; a < 3; a++) begin
        for (int k = 0; k < 3; k++) begin
          rp[a][k] <= $signed(cfg.pose[a][16*k +: 16]) * cam[k];
        end
        tr3[a] <= $signed(cfg.pose[a][63:48]);
        if (wsum[a] > 48'sh7FFF_FFFF) begin
          w4[a] <= 32'h7FFF_FFFF;
        end else if (wsum[a] < -48'sh8000_0000) begin
          w4[a] <= 32'h8000_0000;
        end else begin
          w4[a] <= wsum[a][31:0];
        end
      end
    end
  end

  gdu_recip u_recip (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (v4),
    .in_x      (w4[0]),
    .in_y      (w4[1]),
    .in_z      (w4[2]),
    .out_valid (m_tvalid),
    .out_x     (m_tdata[31:0]),
    .out_y     (m_tdata[63:32]),
    .out_z     (m_tdata[95:64]),
    .out_inten (m_tdata[127:96]),
    .out_bad   (m_tuser)
  );

endmodule

// ===== design/gradient_gated_depth_unprojection.sv =====
// Top level of the gradient-gated depth unprojection block.
// Depends on gdu_pkg, gdu_front, gdu_fifo and gdu_back.
//
// Usage:
//   s_* carries one pixel per beat. Pixels whose squared gradient magnitude
//   falls below threshold_sq are dropped; kept pixels come out on m_* as one
//   world point each, in order.
//   cfg_* writes one register per beat (index, 64-bit data); always ready.
//   Write only while the block is idle.
// Throughput: one pixel per cycle while m_tready does not stall, from the fully
//   pipelined datapath: four arithmetic stages and a 33-stage reciprocal divider,
//   one quotient bit each.
// Stall: a stalled m_tready freezes the back-end pipeline; the queue keeps
//   taking pixels until full, then s_tready drops.
// Reset: rst clears the configuration registers to zero and empties queue
//   and pipeline.
module gradient_gated_depth_unprojection
  import gdu_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // pixel_col[11:0], pixel_row[23:12], gradient_x[39:24], gradient_y[55:40],
  // depth_value[71:56]
  input  logic [71:0]  s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // world_x[31:0], world_y[63:32], world_z[95:64], intensity[127:96]
  output logic [127:0] m_tdata,
  // intensity_invalid[0]
  output logic         m_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  logic [31:0] threshold_sq;
  cam_cfg_t cfg;
  fifo_status_t status;
  logic push;
  logic pop;
  pixel_t wr_item;
  pixel_t rd_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_sq <= '0;
      cfg <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_THRESHOLD: threshold_sq <= cfg_data[31:0];
        REG_PRINCIPAL: cfg.principal <= cfg_data[31:0];
        REG_INV_FOCAL: cfg.inv_focal <= cfg_data;
        REG_POSE_0:    cfg.pose[0] <= cfg_data;
        REG_POSE_1:    cfg.pose[1] <= cfg_data;
        REG_POSE_2:    cfg.pose[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  gdu_front u_front (
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .threshold_sq (threshold_sq),
    .status       (status),
    .push         (push),
    .item         (wr_item)
  );

  gdu_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (wr_item),
    .pop     (pop),
    .rd_item (rd_item),
    .status  (status)
  );

  gdu_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .status   (status),
    .rd_item  (rd_item),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
